@@ src/double_hash_counter_table_top_defines.svh @@
// assertion macros for the double hash counter table
`ifndef DOUBLE_HASH_COUNTER_TABLE_TOP_DEFINES_SVH
`define DOUBLE_HASH_COUNTER_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// checked property, ignored while reset is high
`define DHCT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dhct assertion failed");
// checked property, also during reset
`define DHCT_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("dhct assertion failed");
`else
`define DHCT_ASSERT(lbl, clk, rst, prop)
`define DHCT_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

@@ src/dhct_pkg.sv @@
// shared types and constants of the double hash counter table
package dhct_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int EQUIV_MAX_DEF   = 10;
   localparam int EQUIV_PORTS     = 10;
   localparam int SIZE_W          = 11;
   localparam int CSR_AW          = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
   localparam logic [12:0]       HASH_MUL   = 13'd6812;
   localparam logic [31:0]       EMPTY_KEY  = 32'hFFFF_FFFF;

   // register index decoded from the byte address
   localparam logic REG_TABLE_SIZE = 1'b0;

   // commands
   localparam logic CMD_COUNT  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // result status codes
   localparam logic [2:0] ST_COUNTED  = 3'd0;
   localparam logic [2:0] ST_NEW      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // probe outcomes
   localparam logic [1:0] PR_FOUND = 2'd0;
   localparam logic [1:0] PR_EMPTY = 2'd1;
   localparam logic [1:0] PR_FULL  = 2'd2;

   // hash unit result
   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] h1;
      logic [SIZE_W-1:0] step;
   } hash_res_type;

   // store write request
   typedef struct packed {
      logic        en;
      logic [31:0] key;
      logic [31:0] cnt;
   } store_wr_type;

endpackage

@@ src/dhct_store.sv @@
// key and count memories, one write and one registered read port
module dhct_store import dhct_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic          clock,
   input  store_wr_type  wr,
   input  logic [AW-1:0] wr_addr,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_key,
   output logic [31:0]   rd_cnt
);

   logic [31:0] key_mem [TABLE_DEPTH];
   logic [31:0] cnt_mem [TABLE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr_addr] <= wr.key;
         cnt_mem[wr_addr] <= wr.cnt;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_cnt <= cnt_mem[rd_addr];
      end
   end

endmodule

@@ src/dhct_div.sv @@
// bit-serial remainder unit, one dividend bit per cycle
module dhct_div import dhct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [SIZE_W-1:0] rem
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       dvd_ff, dvd_in;
   logic [SIZE_W-1:0] dsr_ff, dsr_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   trial;

   // restoring step
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[31]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ src/dhct_hash.sv @@
// first hash (decimal mid-square) and probe step of one key
module dhct_hash import dhct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       key,
   input  logic [SIZE_W-1:0] size,
   output hash_res_type      res
);

   localparam logic [3:0] H_IDLE = 4'd0;
   localparam logic [3:0] H_MUL1 = 4'd1;
   localparam logic [3:0] H_MUL2 = 4'd2;
   localparam logic [3:0] H_BCD  = 4'd3;
   localparam logic [3:0] H_LEN  = 4'd4;
   localparam logic [3:0] H_MID  = 4'd5;
   localparam logic [3:0] H_MODA = 4'd6;
   localparam logic [3:0] H_MODB = 4'd7;
   localparam logic [3:0] H_STEP = 4'd8;
   localparam logic [3:0] H_GCD  = 4'd9;
   localparam logic [3:0] H_DONE = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [31:0]       k_ff, k_in;
   logic [31:0]       a_ff, a_in;
   logic              neg_ff, neg_in;
   logic [31:0]       mag_ff, mag_in;
   logic [3:0]        dig_ff [10];
   logic [3:0]        dig_in [10];
   logic [4:0]        cnt_ff, cnt_in;
   logic [3:0]        nd_ff, nd_in;
   logic [3:0]        len_ff, len_in;
   logic signed [4:0] lo_ff, lo_in;
   logic signed [4:0] hi_ff, hi_in;
   logic              mneg_ff, mneg_in;
   logic [3:0]        i_ff, i_in;
   logic [26:0]       mid_ff, mid_in;
   logic [SIZE_W-1:0] h1_ff, h1_in;
   logic [SIZE_W-1:0] x_ff, x_in;
   logic [SIZE_W-1:0] s_ff, s_in;
   logic [SIZE_W-1:0] gu_ff, gu_in;
   logic [SIZE_W-1:0] gv_ff, gv_in;
   logic [SIZE_W-1:0] step_ff, step_in;

   logic              div_start;
   logic [31:0]       div_dvd;
   logic              div_done;
   logic [SIZE_W-1:0] div_rem;

   logic [44:0]       p1;
   logic [63:0]       p2;
   logic [3:0]        adj [10];
   logic [3:0]        nd_c;
   logic [3:0]        half;
   logic [3:0]        didx;
   logic [3:0]        cur_dig;
   logic              in_win;

   dhct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (size),
      .done     (div_done),
      .rem      (div_rem)
   );

   // multiplier products
   assign p1 = k_ff * HASH_MUL;
   assign p2 = a_ff * a_ff;

   // add-3 correction and digit count of the decimal form
   always_comb begin
      nd_c = 4'd1;
      for (int t = 0; t < 10; t++) begin
         adj[t] = (dig_ff[t] >= 4'd5) ? dig_ff[t] + 4'd3 : dig_ff[t];
         if (dig_ff[t] != 4'd0) begin
            nd_c = 4'(t + 1);
         end
      end
   end

   // character under the text cursor
   assign half    = {1'b0, nd_c[3:1]} + {3'b0, (nd_c[0] & neg_ff)};
   assign didx    = nd_ff - 4'd1 - i_ff + {3'b0, neg_ff};
   assign cur_dig = dig_ff[didx];
   assign in_win  = ($signed({1'b0, i_ff}) >= lo_ff) && ($signed({1'b0, i_ff}) <= hi_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      a_in      = a_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      dig_in    = dig_ff;
      cnt_in    = cnt_ff;
      nd_in     = nd_ff;
      len_in    = len_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mneg_in   = mneg_ff;
      i_in      = i_ff;
      mid_in    = mid_ff;
      h1_in     = h1_ff;
      x_in      = x_ff;
      s_in      = s_ff;
      gu_in     = gu_ff;
      gv_in     = gv_ff;
      step_in   = step_ff;
      div_start = 1'b0;
      div_dvd   = k_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               k_in     = key;
               state_in = H_MUL1;
            end
         end
         H_MUL1: begin
            a_in     = p1[31:0];
            state_in = H_MUL2;
         end
         H_MUL2: begin
            neg_in   = p2[31];
            mag_in   = p2[31] ? (32'd0 - p2[31:0]) : p2[31:0];
            for (int t = 0; t < 10; t++) begin
               dig_in[t] = 4'd0;
            end
            cnt_in   = '0;
            state_in = H_BCD;
         end
         // binary to decimal, one bit per cycle
         H_BCD: begin
            dig_in[0] = {adj[0][2:0], mag_ff[31]};
            for (int t = 1; t < 10; t++) begin
               dig_in[t] = {adj[t][2:0], adj[t-1][3]};
            end
            mag_in = {mag_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = H_LEN;
            end
         end
         // text length and the kept window
         H_LEN: begin
            nd_in    = nd_c;
            len_in   = nd_c + {3'b0, neg_ff};
            lo_in    = $signed({1'b0, half}) - 5'sd3;
            hi_in    = $signed({1'b0, half}) + 5'sd4;
            mneg_in  = neg_ff && (half <= 4'd3);
            i_in     = '0;
            mid_in   = '0;
            state_in = H_MID;
         end
         // parse the window, one character per cycle
         H_MID: begin
            if (i_ff == len_ff) begin
               div_start = 1'b1;
               div_dvd   = {5'd0, mid_ff};
               state_in  = H_MODA;
            end else begin
               if (in_win && !(neg_ff && (i_ff == 4'd0))) begin
                  mid_in = 27'({mid_ff, 3'b0} + {mid_ff, 1'b0} + {23'd0, cur_dig});
               end
               i_in = i_ff + 4'd1;
            end
         end
         H_MODA: begin
            if (div_done) begin
               h1_in     = (mneg_ff && (div_rem != '0)) ? size - div_rem : div_rem;
               div_start = 1'b1;
               div_dvd   = k_ff;
               state_in  = H_MODB;
            end
         end
         H_MODB: begin
            if (div_done) begin
               x_in     = div_rem;
               s_in     = div_rem + 1'b1;
               state_in = H_STEP;
            end
         end
         // next step candidate
         H_STEP: begin
            if (s_ff >= size) begin
               step_in  = x_ff;
               state_in = H_DONE;
            end else if (s_ff < SIZE_MIN || (!s_ff[0] && !size[0])) begin
               s_in = s_ff + 1'b1;
            end else begin
               gu_in    = s_ff;
               gv_in    = size;
               state_in = H_GCD;
            end
         end
         // binary gcd, odd common part only
         H_GCD: begin
            if (gu_ff == '0 || gv_ff == '0) begin
               if ((gu_ff | gv_ff) == SIZE_W'(1)) begin
                  step_in  = s_ff;
                  state_in = H_DONE;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = H_STEP;
               end
            end else if (!gu_ff[0]) begin
               gu_in = gu_ff >> 1;
            end else if (!gv_ff[0]) begin
               gv_in = gv_ff >> 1;
            end else if (gu_ff >= gv_ff) begin
               gu_in = gu_ff - gv_ff;
            end else begin
               gv_in = gv_ff - gu_ff;
            end
         end
         H_DONE: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      dig_ff  <= dig_in;
      cnt_ff  <= cnt_in;
      nd_ff   <= nd_in;
      len_ff  <= len_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mneg_ff <= mneg_in;
      i_ff    <= i_in;
      mid_ff  <= mid_in;
      h1_ff   <= h1_in;
      x_ff    <= x_in;
      s_ff    <= s_in;
      gu_ff   <= gu_in;
      gv_ff   <= gv_in;
      step_ff <= step_in;
   end

   assign res.done = (state_ff == H_DONE);
   assign res.h1   = h1_ff;
   assign res.step = step_ff;

endmodule

@@ src/double_hash_counter_table_top.sv @@
// Counting hash table with double hashing: count or look up one product code per command.
// A command is taken when start is high and busy is low; its one result appears on the
// rsp_ ports for a single cycle with rsp_strobe high, and must be taken then. After reset
// the block clears every slot of its memories with busy high. Each code searched first
// passes the hash unit (two remainders from the shared bit-serial divider, a binary to
// decimal pass, the digit parse and the coprime step search), then visits slots through
// the registered memory read, with a read state and a check state per slot. A look-up
// searches one code, a count up to EQUIV_MAX+1 codes, and the result is registered from
// the check of the last probe.
`include "double_hash_counter_table_top_defines.svh"
module double_hash_counter_table_top import dhct_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int EQUIV_MAX   = EQUIV_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [30:0]       req_code,
   input  logic signed [31:0] req_equiv_0,
   input  logic signed [31:0] req_equiv_1,
   input  logic signed [31:0] req_equiv_2,
   input  logic signed [31:0] req_equiv_3,
   input  logic signed [31:0] req_equiv_4,
   input  logic signed [31:0] req_equiv_5,
   input  logic signed [31:0] req_equiv_6,
   input  logic signed [31:0] req_equiv_7,
   input  logic signed [31:0] req_equiv_8,
   input  logic signed [31:0] req_equiv_9,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [9:0]        rsp_slot,
   output logic signed [31:0] rsp_slot_key,
   output logic [31:0]       rsp_count,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_PRD   = 3'd3;
   localparam logic [2:0] S_PCHK  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              hstart_ff, hstart_in;
   logic              cmd_ff, cmd_in;
   logic [30:0]       code_ff, code_in;
   logic [31:0]       equiv_ff [EQUIV_PORTS];
   logic [31:0]       equiv_in [EQUIV_PORTS];
   logic [3:0]        key_idx_ff, key_idx_in;
   logic [SIZE_W-1:0] pos_ff, pos_in;
   logic [SIZE_W-1:0] step_ff, step_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [1:0]        code_res_ff, code_res_in;
   logic [SIZE_W-1:0] code_slot_ff, code_slot_in;
   logic [SIZE_W-1:0] tsize_ff, tsize_in;
   logic              strobe_ff, strobe_in;
   logic [2:0]        status_ff, status_in;
   logic [9:0]        slot_ff, slot_in;
   logic [31:0]       skey_ff, skey_in;
   logic [31:0]       count_ff, count_in;

   logic [SIZE_W-1:0] msize;
   logic [31:0]       cur_key;
   logic [31:0]       rd_key, rd_cnt;
   hash_res_type      hres;
   store_wr_type      wr;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [SIZE_W:0]   pos_sum;
   logic [SIZE_W-1:0] pos_next;
   logic [1:0]        pres;
   logic              resolved;
   logic [1:0]        cres;
   logic [SIZE_W-1:0] cslot;
   logic              more;
   logic              csr_wr;

   // size in use, held between 2 and the table depth
   always_comb begin
      msize = tsize_ff;
      if (tsize_ff < SIZE_MIN) begin
         msize = SIZE_MIN;
      end else if (int'(tsize_ff) > TABLE_DEPTH) begin
         msize = SIZE_W'(TABLE_DEPTH);
      end
   end

   // register port
   assign csr_wr   = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
   assign tsize_in = csr_wr ? pwdata[SIZE_W-1:0] : tsize_ff;
   assign prdata   = (paddr[2] == REG_TABLE_SIZE) ? {21'd0, tsize_ff} : 32'd0;
   assign pready   = 1'b1;

   // key under search: the code itself or one of its equivalents
   assign cur_key = (key_idx_ff == 4'd0) ? {1'b0, code_ff} : equiv_ff[4'(key_idx_ff - 4'd1)];

   dhct_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hstart_ff),
      .key   (cur_key),
      .size  (msize),
      .res   (hres)
   );

   dhct_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (AW'(pos_ff)),
      .rd_key  (rd_key),
      .rd_cnt  (rd_cnt)
   );

   assign rd_en = (state_ff == S_PRD);

   // probe bookkeeping
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff};
   assign pos_next = (pos_sum >= {1'b0, msize}) ? SIZE_W'(pos_sum - {1'b0, msize})
                                                : pos_sum[SIZE_W-1:0];
   always_comb begin
      resolved = 1'b1;
      if (rd_key == cur_key) begin
         pres = PR_FOUND;
      end else if (rd_key == EMPTY_KEY) begin
         pres = PR_EMPTY;
      end else if ((n_ff + 1'b1) == msize) begin
         pres = PR_FULL;
      end else begin
         pres     = PR_FULL;
         resolved = 1'b0;
      end
   end
   assign cres  = (key_idx_ff == 4'd0) ? pres : code_res_ff;
   assign cslot = (key_idx_ff == 4'd0) ? pos_ff : code_slot_ff;
   assign more  = (int'(key_idx_ff) < EQUIV_MAX) && (equiv_ff[key_idx_ff] != EMPTY_KEY);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      hstart_in    = 1'b0;
      cmd_in       = cmd_ff;
      code_in      = code_ff;
      equiv_in     = equiv_ff;
      key_idx_in   = key_idx_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      code_res_in  = code_res_ff;
      code_slot_in = code_slot_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      slot_in      = slot_ff;
      skey_in      = skey_ff;
      count_in     = count_ff;
      wr           = '0;
      wr_addr      = AW'(pos_ff);
      unique case (state_ff)
         S_CLEAR: begin
            wr.en   = 1'b1;
            wr.key  = EMPTY_KEY;
            wr.cnt  = 32'd0;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_cmd;
               code_in     = req_code;
               equiv_in[0] = req_equiv_0;
               equiv_in[1] = req_equiv_1;
               equiv_in[2] = req_equiv_2;
               equiv_in[3] = req_equiv_3;
               equiv_in[4] = req_equiv_4;
               equiv_in[5] = req_equiv_5;
               equiv_in[6] = req_equiv_6;
               equiv_in[7] = req_equiv_7;
               equiv_in[8] = req_equiv_8;
               equiv_in[9] = req_equiv_9;
               key_idx_in  = 4'd0;
               hstart_in   = 1'b1;
               state_in    = S_HASH;
            end
         end
         S_HASH: begin
            if (hres.done) begin
               pos_in   = hres.h1;
               step_in  = hres.step;
               n_in     = '0;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (!resolved) begin
               pos_in   = pos_next;
               n_in     = n_ff + 1'b1;
               state_in = S_PRD;
            end else begin
               if (key_idx_ff == 4'd0) begin
                  code_res_in  = pres;
                  code_slot_in = pos_ff;
               end
               // default answer: no slot
               status_in = ST_NOTFOUND;
               slot_in   = '0;
               skey_in   = EMPTY_KEY;
               count_in  = 32'd0;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               if (cmd_ff == CMD_LOOKUP) begin
                  if (pres == PR_FOUND) begin
                     status_in = ST_FOUND;
                     slot_in   = pos_ff[9:0];
                     skey_in   = rd_key;
                     count_in  = rd_cnt;
                  end
               end else if (pres == PR_FOUND) begin
                  // existing group, saturating count
                  wr.en     = 1'b1;
                  wr.key    = rd_key;
                  wr.cnt    = (rd_cnt == '1) ? rd_cnt : rd_cnt + 32'd1;
                  wr_addr   = AW'(pos_ff);
                  status_in = ST_COUNTED;
                  slot_in   = pos_ff[9:0];
                  skey_in   = rd_key;
                  count_in  = wr.cnt;
               end else if (more) begin
                  strobe_in  = 1'b0;
                  key_idx_in = key_idx_ff + 4'd1;
                  hstart_in  = 1'b1;
                  state_in   = S_HASH;
               end else if (cres == PR_FULL) begin
                  status_in = ST_FULL;
               end else begin
                  // claim a new slot for the code
                  wr.en     = 1'b1;
                  wr.key    = {1'b0, code_ff};
                  wr.cnt    = 32'd1;
                  wr_addr   = AW'(cslot);
                  status_in = ST_NEW;
                  slot_in   = cslot[9:0];
                  skey_in   = {1'b0, code_ff};
                  count_in  = 32'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         hstart_ff <= 1'b0;
         strobe_ff <= 1'b0;
         tsize_ff  <= SIZE_RESET;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         hstart_ff <= hstart_in;
         strobe_ff <= strobe_in;
         tsize_ff  <= tsize_in;
      end
      cmd_ff       <= cmd_in;
      code_ff      <= code_in;
      equiv_ff     <= equiv_in;
      key_idx_ff   <= key_idx_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      n_ff         <= n_in;
      code_res_ff  <= code_res_in;
      code_slot_ff <= code_slot_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      skey_ff      <= skey_in;
      count_ff     <= count_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_slot_key = skey_ff;
   assign rsp_count    = count_ff;

   // checks
   `DHCT_ASSERT_NORST(a_rsp_idle, clock, rsp_strobe |-> !busy)
   `DHCT_ASSERT(a_take_busy, clock, reset, (start && !busy) |=> busy)
   `DHCT_ASSERT(a_status_range, clock, reset, rsp_strobe |-> (rsp_status <= ST_NOTFOUND))
   `DHCT_ASSERT(a_noslot_key, clock, reset, (rsp_strobe && (rsp_status == ST_FULL || rsp_status == ST_NOTFOUND)) |-> (rsp_slot_key == EMPTY_KEY && rsp_count == 32'd0))

endmodule

@@ bench/double_hash_counter_table_top_tb.sv @@
// self-checking bench for the double hash counter table: count and look-up commands, csr size changes
`timescale 1ns / 100ps
module double_hash_counter_table_top_tb;
   import dhct_pkg::*;

   localparam int DEPTH = 1024;
   localparam int EQN   = 10;

   typedef struct {
      logic [2:0]  status;
      logic [9:0]  slot;
      logic [31:0] slot_key;
      logic [31:0] count;
   } sale_result_type;

   // shadow of the table and the queue of results still owed by the block
   class sales_ledger;
      logic [31:0]  keys [DEPTH];
      logic [31:0]  counts [DEPTH];
      logic [10:0]  size_reg;
      sale_result_type owed [$];
      int           errors;

      function void clear();
         for (int i = 0; i < DEPTH; i++) begin
            keys[i] = EMPTY_KEY;
            counts[i] = 0;
         end
         size_reg = SIZE_RESET;
         errors = 0;
      endfunction

      function logic [31:0] modulus();
         if (size_reg < 2) return 2;
         if (size_reg > DEPTH) return DEPTH;
         return size_reg;
      endfunction

      // decimal mid-square hash
      function logic [31:0] mid_square(logic [31:0] k, logic [31:0] m);
         logic [31:0] a, sq, mag, mid, r;
         int dg [12];
         int nd, len, lo, hi;
         bit neg, mneg;
         if (k == 0) return 0;
         a = k * 32'd6812;
         sq = a * a;
         neg = sq[31];
         mag = neg ? -sq : sq;
         nd = 0;
         do begin
            dg[nd] = mag % 10;
            nd++;
            mag = mag / 10;
         end while (mag != 0);
         len = nd + int'(neg);
         lo = len / 2 - 3;
         hi = len / 2 + 4;
         mid = 0;
         mneg = 0;
         for (int i = 0; i < len; i++) begin
            if (i < lo || i > hi) continue;
            if (neg && i == 0) mneg = 1;
            else mid = mid * 10 + dg[len - 1 - i];
         end
         r = mid % m;
         if (mneg && r != 0) r = m - r;
         return r;
      endfunction

      function logic [31:0] stride(logic [31:0] k, logic [31:0] m);
         logic [31:0] x, a, b, t;
         x = k % m;
         for (logic [31:0] s = x + 1; s < m; s++) begin
            a = s;
            b = m;
            while (b != 0) begin
               t = a % b;
               a = b;
               b = t;
            end
            if (s >= 2 && a == 1) return s;
         end
         return x;
      endfunction

      function logic [1:0] search(logic [31:0] k, logic [31:0] m, output logic [9:0] where);
         logic [31:0] pos, st, p;
         pos = mid_square(k, m);
         st = stride(k, m);
         for (int n = 0; n < m; n++) begin
            p = pos % DEPTH;
            if (keys[p] == k) begin
               where = p[9:0];
               return PR_FOUND;
            end
            if (keys[p] == EMPTY_KEY) begin
               where = p[9:0];
               return PR_EMPTY;
            end
            pos = (pos + st) % m;
         end
         where = 0;
         return PR_FULL;
      endfunction

      // predict one command and update the shadow table
      function void note(logic cmd, logic [30:0] code, logic [31:0] eq [EQN]);
         logic [31:0] m;
         logic [1:0]  res;
         logic [9:0]  where;
         sale_result_type r;
         m = modulus();
         res = search({1'b0, code}, m, where);
         if (cmd == CMD_LOOKUP) begin
            r.status = (res == PR_FOUND) ? ST_FOUND : ST_NOTFOUND;
         end else begin
            for (int i = 0; res != PR_FOUND && i < EQN; i++) begin
               if (eq[i] == EMPTY_KEY) break;
               res = search(eq[i], m, where);
            end
            if (res == PR_FOUND) begin
               if (counts[where] != 32'hFFFF_FFFF) counts[where]++;
               r.status = ST_COUNTED;
            end else begin
               res = search({1'b0, code}, m, where);
               if (res == PR_FULL) r.status = ST_FULL;
               else begin
                  keys[where] = {1'b0, code};
                  counts[where] = 1;
                  r.status = ST_NEW;
               end
            end
         end
         if (r.status == ST_FULL || r.status == ST_NOTFOUND) begin
            r.slot = 0;
            r.slot_key = EMPTY_KEY;
            r.count = 0;
         end else begin
            r.slot = where;
            r.slot_key = keys[where];
            r.count = counts[where];
         end
         owed.push_back(r);
      endfunction

      function void check(sale_result_type got);
         sale_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result status %0d slot %0d", $time, got.status, got.slot);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            errors++;
         end
         if (got.slot_key !== want.slot_key) begin
            $display("%0t: slot_key expected %h actual %h", $time, want.slot_key, got.slot_key);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_cmd = 0;
   logic [30:0] req_code = 0;
   logic [31:0] eqv [EQN];
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_slot;
   logic [31:0] rsp_slot_key;
   logic [31:0] rsp_count;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   sales_ledger ledger;
   logic [30:0] pool [24];
   int          idle_pct;

   initial for (int i = 0; i < EQN; i++) eqv[i] = EMPTY_KEY;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   double_hash_counter_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_code(req_code),
      .req_equiv_0(eqv[0]), .req_equiv_1(eqv[1]), .req_equiv_2(eqv[2]),
      .req_equiv_3(eqv[3]), .req_equiv_4(eqv[4]), .req_equiv_5(eqv[5]),
      .req_equiv_6(eqv[6]), .req_equiv_7(eqv[7]), .req_equiv_8(eqv[8]),
      .req_equiv_9(eqv[9]),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_slot_key(rsp_slot_key), .rsp_count(rsp_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // result monitor
   always @(posedge clock) begin
      sale_result_type got;
      if (!reset && rsp_strobe) begin
         got.status = rsp_status;
         got.slot = rsp_slot;
         got.slot_key = rsp_slot_key;
         got.count = rsp_count;
         ledger.check(got);
      end
   end

   // one command transfer, start held until taken
   task automatic send(logic cmd, logic [30:0] code, logic [31:0] eq [EQN]);
      @(negedge clock);
      req_cmd = cmd;
      req_code = code;
      eqv = eq;
      start = 1;
      do @(posedge clock); while (busy);
      ledger.note(cmd, code, eq);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 0;
         repeat ($urandom_range(6)) @(negedge clock);
      end
   endtask

   // size change once the table has settled
   task automatic set_size(logic [10:0] val);
      @(negedge clock);
      start = 0;
      while (ledger.owed.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      while (busy) @(negedge clock);
      psel = 1;
      pwrite = 1;
      paddr = {REG_TABLE_SIZE, 2'b00};
      pwdata = {21'd0, val};
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      ledger.size_reg = val;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   function automatic logic [31:0] pick_equiv();
      int r;
      r = $urandom_range(99);
      if (r < 65) return {1'b0, pool[$urandom_range(23)]};
      if (r < 80) return $urandom;
      if (r < 90) return -$urandom_range(2, 1000);
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   task automatic random_item();
      logic [31:0] eq [EQN];
      logic        cmd;
      logic [30:0] code;
      int          n;
      cmd = ($urandom_range(99) < 35) ? CMD_LOOKUP : CMD_COUNT;
      code = ($urandom_range(99) < 80) ? pool[$urandom_range(23)] : 31'($urandom);
      n = $urandom_range(EQN);
      for (int i = 0; i < EQN; i++) eq[i] = (i < n) ? pick_equiv() : pick_equiv();
      if (n < EQN) eq[n] = EMPTY_KEY;
      send(cmd, code, eq);
   endtask

   initial begin
      logic [31:0] eq [EQN];
      logic [10:0] sizes [10] = '{11'd1024, 11'd16, 11'd2, 11'd7, 11'd1, 11'd2047,
                                  11'd13, 11'd0, 11'd64, 11'd1024};
      ledger = new();
      ledger.clear();
      idle_pct = 0;
      pool[0] = 0;
      pool[1] = 31'h7FFF_FFFF;
      for (int i = 2; i < 24; i++) pool[i] = (i < 14) ? 31'(i * 37) : 31'($urandom);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, both commands, equivalent matching and terminators
      for (int i = 0; i < EQN; i++) eq[i] = EMPTY_KEY;
      send(CMD_LOOKUP, 31'd0, eq);
      send(CMD_COUNT, 31'd0, eq);
      send(CMD_COUNT, 31'd0, eq);
      send(CMD_COUNT, 31'h7FFF_FFFF, eq);
      send(CMD_LOOKUP, 31'h7FFF_FFFF, eq);
      send(CMD_LOOKUP, 31'd12345, eq);
      eq[0] = 32'h8000_0000;
      eq[1] = -32'sd5;
      eq[2] = 32'h7FFF_FFFF;
      send(CMD_COUNT, 31'd999, eq);
      for (int i = 0; i < EQN; i++) eq[i] = 32'h7FFF_FFF0 + i;
      send(CMD_COUNT, 31'd4242, eq);
      eq[9] = 32'd0;
      send(CMD_COUNT, 31'd777, eq);
      eq[0] = EMPTY_KEY;
      eq[1] = 32'd0;
      send(CMD_COUNT, 31'd778, eq);
      send(CMD_LOOKUP, 31'd4242, eq);

      // random phases over several sizes and idling patterns
      foreach (sizes[p]) begin
         set_size(sizes[p]);
         for (int i = 0; i < 160; i++) begin
            case ((i / 40) % 4)
               0: idle_pct = 0;
               1: idle_pct = 48;
               2: idle_pct = 0;
               default: idle_pct = 7;
            endcase
            random_item();
         end
      end

      @(negedge clock);
      start = 0;
      while (ledger.owed.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (ledger.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #400000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
